FILE: hdl/stable_priority_queue_macros.svh
// Assertion macros used by the priority queue top level.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hdl/spq_pkg.sv
// Types and constants of the stable priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  localparam int TAG_FIELD_W   = 16;
  localparam int CLASS_W       = 2;
  localparam int STATUS_W      = 2;
  localparam int COUNT_FIELD_W = 5;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [CLASS_W-1:0] cls;
  } spq_op_t;

endpackage

FILE: hdl/spq_cell.sv
// One slot of the queue chain: holds a tag and class, shifts with its neighbors.
module spq_cell import spq_pkg::*; #(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  spq_op_t             op,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic                occ,
  input  logic                prev_keep,
  input  logic [TAG_BITS-1:0] prev_tag,
  input  logic [CLASS_W-1:0]  prev_cls,
  input  logic [TAG_BITS-1:0] next_tag,
  input  logic [CLASS_W-1:0]  next_cls,
  output logic                keep,
  output logic [TAG_BITS-1:0] tag_q,
  output logic [CLASS_W-1:0]  cls_q
);

  logic [TAG_BITS-1:0] slot_tag_r, slot_tag_nxt;
  logic [CLASS_W-1:0]  slot_cls_r, slot_cls_nxt;

  // An occupied slot of equal or higher urgency stays ahead of the new word.
  assign keep = occ && (slot_cls_r <= op.cls);

  always_comb begin
    slot_tag_nxt = slot_tag_r;
    slot_cls_nxt = slot_cls_r;
    if (op.push && !keep) begin
      if (prev_keep) begin
        slot_tag_nxt = new_tag;
        slot_cls_nxt = op.cls;
      end else begin
        slot_tag_nxt = prev_tag;
        slot_cls_nxt = prev_cls;
      end
    end else if (op.pop) begin
      slot_tag_nxt = next_tag;
      slot_cls_nxt = next_cls;
    end
  end

  always_ff @(posedge clk) begin
    slot_tag_r <= slot_tag_nxt;
    slot_cls_r <= slot_cls_nxt;
  end

  assign tag_q = slot_tag_r;
  assign cls_q = slot_cls_r;

endmodule

FILE: hdl/stable_priority_queue.sv
// Top level of the stable four-class priority queue.
// Bounded priority queue of QUEUE_DEPTH entries kept in service order, head
// first, in a chain of slot cells. A push (command 0) inserts the tag behind
// every stored entry of equal or more urgent class (class 0 most urgent), so
// each class is first in, first out; a pop (command 1) removes the head.
// Every accepted command gives one result word on the out_ ports in the next
// cycle, marked by out_strobe for a single cycle; the receiver cannot stall,
// so it must take that word then. All slots compare against the new class and
// shift in the same cycle, so one command is taken every cycle and busy stays
// low. A push on a full queue is dropped with status 2; a pop on an empty
// queue is ignored with status 1. out_entry_count is the occupancy after the
// command, kept to its low five bits.
module stable_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic [TAG_FIELD_W-1:0]   in_item_tag,
  input  logic [CLASS_W-1:0]       in_urgency_class,
  output logic                     out_strobe,
  output logic                     out_popped_valid,
  output logic [TAG_FIELD_W-1:0]   out_popped_tag,
  output logic [CLASS_W-1:0]       out_popped_class,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_FIELD_W-1:0] out_entry_count
);

`include "stable_priority_queue_macros.svh"

  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               accept, is_pop, full, empty, do_push, do_pop;
  spq_op_t            op;

  logic [TAG_FIELD_W+TAG_BITS-1:0] in_tag_ext;
  logic [TAG_BITS-1:0]             new_tag;
  logic [TAG_FIELD_W+TAG_BITS-1:0] head_tag_ext;
  logic [COUNT_W+COUNT_FIELD_W-1:0] count_ext;

  logic [TAG_BITS-1:0] cell_tag  [QUEUE_DEPTH];
  logic [CLASS_W-1:0]  cell_cls  [QUEUE_DEPTH];
  logic                cell_keep [QUEUE_DEPTH];
  logic                cell_occ  [QUEUE_DEPTH];

  logic                    out_strobe_r, out_popped_valid_r;
  logic [TAG_FIELD_W-1:0]  out_popped_tag_r;
  logic [CLASS_W-1:0]      out_popped_class_r;
  status_t                 out_status_r, status_nxt;
  logic [COUNT_FIELD_W-1:0] out_entry_count_r;

  // The chain takes a command every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_pop = (cmd_t'(in_command) == CMD_POP);
  assign full   = (count_r == COUNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);

  assign do_push = accept && !is_pop && !full;
  assign do_pop  = accept && is_pop && !empty;

  assign in_tag_ext = {{TAG_BITS{1'b0}}, in_item_tag};
  assign new_tag    = in_tag_ext[TAG_BITS-1:0];

  assign op.push = do_push;
  assign op.pop  = do_pop;
  assign op.cls  = in_urgency_class;

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - COUNT_W'(1);
    end
  end

  always_comb begin
    status_nxt = ST_DONE;
    if (is_pop && empty) begin
      status_nxt = ST_EMPTY;
    end else if (!is_pop && full) begin
      status_nxt = ST_FULL;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                prev_keep;
    logic [TAG_BITS-1:0] prev_tag, next_tag;
    logic [CLASS_W-1:0]  prev_cls, next_cls;

    assign cell_occ[i] = (COUNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign prev_tag  = new_tag;
      assign prev_cls  = in_urgency_class;
    end else begin : g_body
      assign prev_keep = cell_keep[i-1];
      assign prev_tag  = cell_tag[i-1];
      assign prev_cls  = cell_cls[i-1];
    end

    // The tail cell holds on pop; its stale word lies beyond the count.
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_tag = cell_tag[i];
      assign next_cls = cell_cls[i];
    end else begin : g_mid
      assign next_tag = cell_tag[i+1];
      assign next_cls = cell_cls[i+1];
    end

    spq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .new_tag   (new_tag),
      .occ       (cell_occ[i]),
      .prev_keep (prev_keep),
      .prev_tag  (prev_tag),
      .prev_cls  (prev_cls),
      .next_tag  (next_tag),
      .next_cls  (next_cls),
      .keep      (cell_keep[i]),
      .tag_q     (cell_tag[i]),
      .cls_q     (cell_cls[i])
    );
  end

  assign head_tag_ext = {{TAG_FIELD_W{1'b0}}, cell_tag[0]};
  assign count_ext    = {{COUNT_FIELD_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= accept;
    end
  end

  // Result word payload; zero the popped fields unless an entry left.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_popped_valid_r <= do_pop;
      out_popped_tag_r   <= do_pop ? head_tag_ext[TAG_FIELD_W-1:0] : '0;
      out_popped_class_r <= do_pop ? cell_cls[0] : '0;
      out_status_r       <= status_nxt;
      out_entry_count_r  <= count_ext[COUNT_FIELD_W-1:0];
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_popped_valid = out_popped_valid_r;
  assign out_popped_tag   = out_popped_tag_r;
  assign out_popped_class = out_popped_class_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_entry_count_r;

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= COUNT_W'(QUEUE_DEPTH))
  `SPQ_ASSERT_NEXT(a_push_grows, do_push, count_r == $past(count_r) + COUNT_W'(1))
  `SPQ_ASSERT_NEXT(a_one_word_per_cmd, 1'b1, out_strobe == $past(accept))
  `SPQ_ASSERT_NOW(a_pop_done, out_strobe && out_popped_valid, out_status == ST_DONE)
  `SPQ_ASSERT_NOW(a_head_order, count_r >= COUNT_W'(2), cell_cls[0] <= cell_cls[1])

endmodule

FILE: tb/sv/spq_order_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the service order of the priority queue and compares each result word.
module spq_order_checker import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_command,
  input  logic [TAG_FIELD_W-1:0]   in_item_tag,
  input  logic [CLASS_W-1:0]       in_urgency_class,
  input  logic                     out_strobe,
  input  logic                     out_popped_valid,
  input  logic [TAG_FIELD_W-1:0]   out_popped_tag,
  input  logic [CLASS_W-1:0]       out_popped_class,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic [COUNT_FIELD_W-1:0] out_entry_count,
  output int                       mismatches,
  output int                       awaiting
);

  localparam logic [TAG_FIELD_W-1:0] TAG_KEEP =
      (TAG_BITS >= TAG_FIELD_W) ? '1 : TAG_FIELD_W'((64'd1 << TAG_BITS) - 1);

  typedef struct packed {
    logic                     valid;
    logic [TAG_FIELD_W-1:0]   tag;
    logic [CLASS_W-1:0]       cls;
    status_t                  status;
    logic [COUNT_FIELD_W-1:0] count;
  } pop_result_t;

  logic [TAG_FIELD_W-1:0] held_tag   [QUEUE_DEPTH];
  logic [CLASS_W-1:0]     held_class [QUEUE_DEPTH];
  int                     held_count;
  pop_result_t            due_words [$];
  int                     errs;

  initial begin
    held_count = 0;
    errs       = 0;
    mismatches = 0;
    awaiting   = 0;
  end

  // Apply one command to the held entries and return the word it must produce.
  function automatic pop_result_t apply_command(cmd_t cmd, logic [TAG_FIELD_W-1:0] tag,
                                                logic [CLASS_W-1:0] cls);
    pop_result_t res;
    int          slot;
    res        = '0;
    res.status = ST_DONE;
    if (cmd == CMD_PUSH) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // insert behind every entry of equal or more urgent class
        slot = 0;
        while (slot < held_count && held_class[slot] <= cls) slot++;
        for (int k = held_count; k > slot; k--) begin
          held_tag[k]   = held_tag[k-1];
          held_class[k] = held_class[k-1];
        end
        held_tag[slot]   = tag & TAG_KEEP;
        held_class[slot] = cls;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.valid = 1'b1;
      res.tag   = held_tag[0];
      res.cls   = held_class[0];
      for (int k = 1; k < held_count; k++) begin
        held_tag[k-1]   = held_tag[k];
        held_class[k-1] = held_class[k];
      end
      held_count--;
    end
    res.count = COUNT_FIELD_W'(held_count);
    return res;
  endfunction

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    pop_result_t want;
    if (!rst_n) begin
      held_count = 0;
      due_words.delete();
    end else begin
      // predict first, so a same-cycle answer still lines up with its command
      if (start && !busy)
        due_words.push_back(apply_command(cmd_t'(in_command), in_item_tag, in_urgency_class));
      if (out_strobe) begin
        if (due_words.size() == 0) begin
          $error("result word with no command waiting for it");
          errs++;
        end else begin
          want = due_words.pop_front();
          compare_field("popped_valid", want.valid, out_popped_valid);
          compare_field("popped_tag", want.tag, out_popped_tag);
          compare_field("popped_class", want.cls, out_popped_class);
          compare_field("status", want.status, out_status);
          compare_field("entry_count", want.count, out_entry_count);
        end
      end
    end
    awaiting   <= due_words.size();
    mismatches <= errs;
  end

endmodule

FILE: tb/sv/tb_stable_priority_queue.sv
`timescale 1ns / 1ps
// Top of the priority queue testbench: clock, reset, push and pop stimulus, and the verdict.
module tb_stable_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH          = QUEUE_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 308;
  localparam int MAX_GAP        = 8;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_command;
  logic [TAG_FIELD_W-1:0]   in_item_tag;
  logic [CLASS_W-1:0]       in_urgency_class;
  logic                     out_strobe;
  logic                     out_popped_valid;
  logic [TAG_FIELD_W-1:0]   out_popped_tag;
  logic [CLASS_W-1:0]       out_popped_class;
  logic [STATUS_W-1:0]      out_status;
  logic [COUNT_FIELD_W-1:0] out_entry_count;
  int                       mismatches;
  int                       awaiting;
  int                       idle_cycles;

  stable_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_item_tag      (in_item_tag),
    .in_urgency_class (in_urgency_class),
    .out_strobe       (out_strobe),
    .out_popped_valid (out_popped_valid),
    .out_popped_tag   (out_popped_tag),
    .out_popped_class (out_popped_class),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

  spq_order_checker order_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_item_tag      (in_item_tag),
    .in_urgency_class (in_urgency_class),
    .out_strobe       (out_strobe),
    .out_popped_valid (out_popped_valid),
    .out_popped_tag   (out_popped_tag),
    .out_popped_class (out_popped_class),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .mismatches       (mismatches),
    .awaiting         (awaiting)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // End the run when neither channel moves for too long.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** stable_priority_queue: FAILED **");
        $finish;
      end
    end
  end

  // Present one word and hold it until taken.
  task automatic send_word(cmd_t cmd, logic [TAG_FIELD_W-1:0] tag, logic [CLASS_W-1:0] cls);
    @(negedge clk);
    start            <= 1'b1;
    in_command       <= cmd;
    in_item_tag      <= tag;
    in_urgency_class <= cls;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Hold the sender until every predicted word has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (awaiting != 0) @(posedge clk);
  endtask

  function automatic logic [TAG_FIELD_W-1:0] pick_tag();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return TAG_FIELD_W'($urandom);
    endcase
  endfunction

  initial begin
    int push_pct [6];
    int burst_left;
    int sent;
    int fixed_class;
    cmd_t cmd;
    logic [CLASS_W-1:0] cls;

    push_pct = '{70, 50, 30, 85, 15, 55};
    rst_n            = 1'b0;
    start            = 1'b0;
    in_command       = CMD_PUSH;
    in_item_tag      = '0;
    in_urgency_class = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: pop on empty, fill with classes in reverse order, push on full, a few pops
    send_word(CMD_POP, 16'h1234, 2'd1);
    for (int i = 0; i < DEPTH; i++) begin
      send_word(CMD_PUSH,
                (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'hA5A5 ^ TAG_FIELD_W'(i * 16'h1111),
                CLASS_W'(3 - (i % 4)));
    end
    send_word(CMD_PUSH, 16'hBEEF, 2'd0);
    repeat (3) send_word(CMD_POP, 16'hFFFF, 2'd3);
    drain_results();

    // random phases, each with its own push/pop balance
    foreach (push_pct[p]) begin
      sent = 0;
      while (sent < PHASE_WORDS) begin
        burst_left  = $urandom_range(1, 20);
        fixed_class = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3)) : -1;
        while (burst_left > 0 && sent < PHASE_WORDS) begin
          cmd = ($urandom_range(0, 99) < push_pct[p]) ? CMD_PUSH : CMD_POP;
          cls = (fixed_class >= 0) ? CLASS_W'(fixed_class) : CLASS_W'($urandom_range(0, 3));
          send_word(cmd, pick_tag(), cls);
          burst_left--;
          sent++;
        end
        // leave some bursts back to back
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, MAX_GAP));
      end
      drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("** stable_priority_queue: PASSED **");
    end else begin
      $display("** stable_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
